// ===== design/olmi_pkg.sv =====
package olmi_pkg;

  typedef struct packed {
    logic signed [31:0] state0_now;
    logic signed [31:0] state1_now;
    logic signed [31:0] state0_before;
    logic signed [31:0] state1_before;
    logic signed [31:0] drive_value;
  } in_beat_t;

  typedef struct packed {
    logic signed [31:0] coef_a00;
    logic signed [31:0] coef_a01;
    logic signed [31:0] coef_a10;
    logic signed [31:0] coef_a11;
    logic signed [31:0] coef_b0;
    logic signed [31:0] coef_b1;
    logic signed [31:0] error0;
    logic signed [31:0] error1;
    logic        [30:0] smoothed_loss;
  } out_beat_t;

  localparam logic [0:0] REG_LEARNING_RATE = 1'd0;
  localparam logic [0:0] REG_MOMENTUM      = 1'd1;
  localparam logic [31:0] LR_RESET   = 32'd4294967;
  localparam logic [31:0] MOM_RESET  = 32'd4252017623;
  localparam logic [32:0] LOSS_KEEP  = 33'd3865470566;
  localparam logic [32:0] ONE_Q32    = 33'h1_0000_0000;

endpackage

// ===== design/olmi_mul.sv =====
// Registered signed multiply, then half-up rounding shift and saturation.
module olmi_mul #(
  parameter int DW = 32,
  parameter int OW = 34
) (
  input  logic                 clk,
  input  logic signed [OW-1:0] op_a,
  input  logic signed [OW-1:0] op_b,
  input  logic                 shift_q32,
  input  logic [6:0]           frac,
  output logic signed [DW-1:0] res
);
  localparam int PW = 2 * OW;
  logic signed [PW-1:0] prod_r;
  logic                 q32_r;
  logic signed [PW:0]   rnd;
  logic signed [PW:0]   shd;
  logic [6:0]           sh;
  logic signed [PW:0]   hi_lim;
  logic signed [PW:0]   lo_lim;

  always_ff @(posedge clk) begin
    prod_r <= PW'(op_a) * PW'(op_b);
    q32_r  <= shift_q32;
  end

  always_comb begin
    sh     = q32_r ? 7'd32 : frac;
    rnd    = (PW + 1)'(prod_r) + ((PW + 1)'(1) <<< (sh - 7'd1));
    shd    = rnd >>> sh;
    hi_lim = (PW + 1)'({1'b0, {(DW - 1){1'b1}}});
    lo_lim = -hi_lim - (PW + 1)'(1);
    if (shd > hi_lim)      res = {1'b0, {(DW - 1){1'b1}}};
    else if (shd < lo_lim) res = {1'b1, {(DW - 1){1'b0}}};
    else                   res = shd[DW-1:0];
  end
endmodule

// ===== design/online_linear_model_identification.sv =====
// One item in flight: no new input beat is accepted until the result beat has been taken.
// The work is serialized on the single shared multiplier: 34 products, each issued as a
// registered product, then shift/saturate and accumulate, followed by the result register
// (ST_DONE), the result beat (ST_OUT) and the idle accept state.
// Coefficients and gradients live in a 6-entry memory each, read through a registered port ahead of use.
// Reset (synchronous, active low) clears control and loss; coefficients and gradients are
// then cleared entry by entry in ST_CLR, and no item is accepted during that sweep.
module online_linear_model_identification #(
  parameter int DATA_WIDTH = 32,
  parameter int FRAC_BITS  = 24
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  olmi_pkg::in_beat_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output olmi_pkg::out_beat_t out_data,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [0:0]          cfg_index,
  input  logic [31:0]         cfg_data
);
  localparam int DW = DATA_WIDTH;
  // multiplier operands must hold a full Q0.32 factor up to 1.0
  localparam int OW = (DW > 33) ? DW + 1 : 34;
  localparam logic signed [DW+1:0] MAXV = (DW + 2)'({1'b0, {(DW - 1){1'b1}}});
  localparam logic signed [DW+1:0] MINV = -MAXV - (DW + 2)'(1);

  typedef enum logic [4:0] {
    ST_CLR  = 5'b00001,
    ST_IDLE = 5'b00010,
    ST_RUN  = 5'b00100,
    ST_DONE = 5'b01000,
    ST_OUT  = 5'b10000
  } state_t;

  function automatic logic signed [DW-1:0] sat_add(input logic signed [DW-1:0] a,
                                                     input logic signed [DW-1:0] b,
                                                     input logic neg_b);
    logic signed [DW+1:0] s;
    s = neg_b ? (DW + 2)'(a) - (DW + 2)'(b) : (DW + 2)'(a) + (DW + 2)'(b);
    if (s > MAXV) return MAXV[DW-1:0];
    if (s < MINV) return MINV[DW-1:0];
    return s[DW-1:0];
  endfunction

  function automatic logic signed [DW-1:0] sat_w(input logic signed [DW+1:0] s);
    if (s > MAXV) return MAXV[DW-1:0];
    if (s < MINV) return MINV[DW-1:0];
    return s[DW-1:0];
  endfunction

  function automatic logic signed [DW-1:0] in_sat(input logic signed [31:0] x);
    logic signed [63:0] v;
    logic signed [63:0] hi;
    v  = 64'(x);
    hi = 64'(MAXV);
    if (v > hi) return MAXV[DW-1:0];
    if (v < -hi - 64'sd1) return MINV[DW-1:0];
    return v[DW-1:0];
  endfunction

  function automatic logic signed [31:0] out_sat(input logic signed [DW-1:0] x);
    logic signed [63:0] v;
    v = 64'(x);
    if (v > 64'sd2147483647) return 32'sh7fffffff;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  state_t state_r, state_nxt;
  logic [31:0] lr_r, mom_r;
  logic [5:0]  step_r;
  logic        ph_r;
  logic [2:0]  clr_r;
  logic [2:0]  k_r;
  logic [1:0]  sub_r;

  logic signed [DW-1:0] coef_mem [6];
  logic signed [DW-1:0] grad_mem [6];
  logic signed [DW-1:0] coef_rd_r, grad_rd_r;
  logic [2:0] rd_addr;
  logic       wr_coef, wr_grad;
  logic [2:0] wr_addr;
  logic signed [DW-1:0] wr_val;

  logic signed [DW-1:0] x0_r, x1_r, p0_r, p1_r, u_r;
  logic signed [DW+1:0] acc_r;
  logic signed [DW-1:0] e0_r, e1_r, loss_r, gtmp_r;
  logic signed [DW-1:0] c_out_r [6];
  logic signed [OW-1:0] ma, mb;
  logic                 mq32;
  logic signed [DW-1:0] mres;
  olmi_pkg::out_beat_t  out_r;

  olmi_mul #(.DW(DW), .OW(OW)) u_mul (
    .clk(clk), .op_a(ma), .op_b(mb), .shift_q32(mq32),
    .frac(7'(FRAC_BITS)), .res(mres)
  );

  // Step schedule (each step: ph 0 issues multiply, ph 1 consumes result).
  // 0..5   : prediction terms h0 = c0 p0 + c1 p1 + c4 u, h1 = c2 p0 + c3 p1 + c5 u
  // 6..23  : per coef i (k=i): steps 6+3i: e*op, 7+3i: m*g then (1-m)*prod,
  //          8+3i: lr*g
  // 24..27 : e0^2, e1^2, keep*L, take*sq

  // gradient needs two products; the pair index gph_r adds a second pass within the same step
  logic gph_r;
  logic signed [DW-1:0] prod_r;

  function automatic logic signed [DW-1:0] op_of(input logic [2:0] i,
                                                  input logic signed [DW-1:0] p0,
                                                  input logic signed [DW-1:0] p1,
                                                  input logic signed [DW-1:0] u);
    case (i)
      3'd0, 3'd2: return p0;
      3'd1, 3'd3: return p1;
      default:    return u;
    endcase
  endfunction

  function automatic logic [2:0] pidx(input logic [2:0] s);
    case (s)
      3'd0: return 3'd0;
      3'd1: return 3'd1;
      3'd2: return 3'd4;
      3'd3: return 3'd2;
      3'd4: return 3'd3;
      default: return 3'd5;
    endcase
  endfunction

  logic [2:0] pred_idx;
  always_comb begin
    pred_idx = pidx(step_r[2:0]);
  end

  // coefficient operand is used in ph 0, so the read runs one step ahead in ph 1
  always_comb begin
    if (state_r == ST_RUN && step_r < 6'd6)
      rd_addr = ph_r ? pidx(step_r[2:0] + 3'd1) : pred_idx;
    else if (state_r == ST_RUN && step_r < 6'd24)
      rd_addr = k_r;
    else
      rd_addr = 3'd0;
  end

  always_comb begin
    ma = '0; mb = '0; mq32 = 1'b0;
    if (step_r < 6'd6) begin
      ma = OW'(coef_rd_r);
      mb = OW'(op_of(pred_idx, p0_r, p1_r, u_r));
    end else if (step_r < 6'd24) begin
      case (sub_r)
        2'd0: begin
          ma = OW'((k_r == 3'd0 || k_r == 3'd1 || k_r == 3'd4) ? e0_r : e1_r);
          mb = OW'(op_of(k_r, p0_r, p1_r, u_r));
        end
        2'd1: begin
          mq32 = 1'b1;
          if (!gph_r) begin
            ma = OW'($signed({1'b0, mom_r}));
            mb = OW'(grad_rd_r);
          end else begin
            ma = OW'($signed({1'b0, olmi_pkg::ONE_Q32 - {1'b0, mom_r}}));
            mb = OW'(prod_r);
          end
        end
        default: begin
          mq32 = 1'b1;
          ma = OW'($signed({1'b0, lr_r}));
          mb = OW'(gtmp_r);
        end
      endcase
    end else begin
      case (step_r)
        6'd24: begin ma = OW'(e0_r); mb = OW'(e0_r); end
        6'd25: begin ma = OW'(e1_r); mb = OW'(e1_r); end
        6'd26: begin
          mq32 = 1'b1; ma = OW'($signed({1'b0, olmi_pkg::LOSS_KEEP})); mb = OW'(loss_r);
        end
        default: begin
          mq32 = 1'b1;
          ma = OW'($signed({1'b0, olmi_pkg::ONE_Q32 - olmi_pkg::LOSS_KEEP}));
          mb = OW'(gtmp_r);
        end
      endcase
    end
  end

  always_comb begin
    wr_coef = 1'b0; wr_grad = 1'b0; wr_addr = k_r; wr_val = '0;
    if (state_r == ST_CLR) begin
      wr_coef = 1'b1; wr_grad = 1'b1; wr_addr = clr_r;
    end else if (state_r == ST_RUN && ph_r && step_r >= 6'd6 && step_r < 6'd24) begin
      if (sub_r == 2'd1 && gph_r) begin
        wr_grad = 1'b1; wr_val = sat_add(gtmp_r, mres, 1'b0);
      end else if (sub_r == 2'd2) begin
        wr_coef = 1'b1; wr_val = sat_add(coef_rd_r, mres, 1'b0);
      end
    end
  end

  always_ff @(posedge clk) begin
    coef_rd_r <= coef_mem[rd_addr];
    grad_rd_r <= grad_mem[rd_addr];
    if (wr_coef) coef_mem[wr_addr] <= wr_val;
    if (wr_grad) grad_mem[wr_addr] <= wr_val;
  end

  assign in_stall  = (state_r != ST_IDLE);
  assign cfg_ready = 1'b1;
  assign out_valid = (state_r == ST_OUT);
  assign out_data  = out_r;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_CLR:  if (clr_r == 3'd5) state_nxt = ST_IDLE;
      ST_IDLE: if (in_valid) state_nxt = ST_RUN;
      ST_RUN:  if (ph_r && step_r == 6'd27) state_nxt = ST_DONE;
      ST_DONE: state_nxt = ST_OUT;
      ST_OUT:  if (!out_stall) state_nxt = ST_IDLE;
      default: state_nxt = ST_CLR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLR;
      clr_r   <= 3'd0;
      lr_r    <= olmi_pkg::LR_RESET;
      mom_r   <= olmi_pkg::MOM_RESET;
      step_r  <= '0;
      ph_r    <= 1'b0;
      gph_r   <= 1'b0;
      k_r     <= 3'd0;
      sub_r   <= 2'd0;
      loss_r  <= '0;
    end else begin
      state_r <= state_nxt;
      if (state_r == ST_CLR) clr_r <= clr_r + 3'd1;
      if (cfg_valid) begin
        if (cfg_index == olmi_pkg::REG_LEARNING_RATE) lr_r <= cfg_data;
        else if (cfg_index == olmi_pkg::REG_MOMENTUM) mom_r <= cfg_data;
      end
      if (state_r == ST_IDLE && in_valid) begin
        step_r <= '0; ph_r <= 1'b0; gph_r <= 1'b0; k_r <= 3'd0; sub_r <= 2'd0;
      end else if (state_r == ST_RUN) begin
        ph_r <= ~ph_r;
        if (ph_r) begin
          if (step_r >= 6'd6 && step_r < 6'd24 && sub_r == 2'd1 && !gph_r) begin
            gph_r <= 1'b1;
          end else begin
            gph_r  <= 1'b0;
            step_r <= step_r + 6'd1;
            if (step_r >= 6'd6 && step_r < 6'd24) begin
              if (sub_r == 2'd2) begin
                sub_r <= 2'd0;
                k_r   <= k_r + 3'd1;
              end else begin
                sub_r <= sub_r + 2'd1;
              end
            end
          end
          if (step_r == 6'd27) loss_r <= sat_w(acc_r + (DW + 2)'(mres));
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_IDLE && in_valid) begin
      x0_r <= in_sat(in_data.state0_now);
      x1_r <= in_sat(in_data.state1_now);
      p0_r <= in_sat(in_data.state0_before);
      p1_r <= in_sat(in_data.state1_before);
      u_r  <= in_sat(in_data.drive_value);
    end
    if (state_r == ST_RUN && ph_r) begin
      if (step_r < 6'd6) begin
        // three-term sums saturate once, at the end
        if (step_r == 6'd0 || step_r == 6'd3) acc_r <= (DW + 2)'(mres);
        else acc_r <= acc_r + (DW + 2)'(mres);
        if (step_r == 6'd2) e0_r <= sat_add(x0_r, sat_w(acc_r + (DW + 2)'(mres)), 1'b1);
        if (step_r == 6'd5) e1_r <= sat_add(x1_r, sat_w(acc_r + (DW + 2)'(mres)), 1'b1);
      end else if (step_r < 6'd24) begin
        case (sub_r)
          2'd0: prod_r <= mres;
          2'd1: begin
            if (!gph_r) gtmp_r <= mres;
            else gtmp_r <= sat_add(gtmp_r, mres, 1'b0);
          end
          default: c_out_r[k_r] <= sat_add(coef_rd_r, mres, 1'b0);
        endcase
      end else begin
        case (step_r)
          6'd24: acc_r <= (DW + 2)'(mres);
          6'd25: gtmp_r <= sat_w(acc_r + (DW + 2)'(mres));
          6'd26: acc_r <= (DW + 2)'(mres);
          default: gtmp_r <= sat_w(acc_r + (DW + 2)'(mres));
        endcase
      end
    end
    if (state_r == ST_DONE) begin
      out_r.coef_a00 <= out_sat(c_out_r[0]);
      out_r.coef_a01 <= out_sat(c_out_r[1]);
      out_r.coef_a10 <= out_sat(c_out_r[2]);
      out_r.coef_a11 <= out_sat(c_out_r[3]);
      out_r.coef_b0  <= out_sat(c_out_r[4]);
      out_r.coef_b1  <= out_sat(c_out_r[5]);
      out_r.error0   <= out_sat(e0_r);
      out_r.error1   <= out_sat(e1_r);
      out_r.smoothed_loss <= loss_r[DW-1] ? 31'd0 : 31'(out_sat(loss_r));
    end
  end
endmodule
